/* src/multibyte_text_validator_assert.svh */
// ----------------------------------------------------------------------------
// multibyte_text_validator_assert.svh
// shared assertion macros for the validator modules
// ----------------------------------------------------------------------------
`ifndef MULTIBYTE_TEXT_VALIDATOR_ASSERT_SVH
`define MULTIBYTE_TEXT_VALIDATOR_ASSERT_SVH

// same-cycle implication, expects clk and rst in scope
`define MTV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, expects clk and rst in scope
`define MTV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mtv_pkg.sv */
// ----------------------------------------------------------------------------
// mtv_pkg
// encoding codes and the classified item record shared by the validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtv_pkg;

  typedef enum logic [1:0] {
    MODE_UTF8   = 2'd0,
    MODE_GB2312 = 2'd1,
    MODE_GBK    = 2'd2,
    MODE_BIG5   = 2'd3
  } mode_t;

  // byte range limits
  localparam logic [7:0] ASCII_TOP    = 8'h7F;
  localparam logic [7:0] U8_CONT_LO   = 8'h80;
  localparam logic [7:0] U8_CONT_HI   = 8'hBF;
  localparam logic [7:0] U8_LEAD2_LO  = 8'hC0;
  localparam logic [7:0] U8_LEAD3_LO  = 8'hE0;
  localparam logic [7:0] U8_LEAD4_LO  = 8'hF0;
  localparam logic [7:0] U8_LEAD_END  = 8'hF8;
  localparam logic [7:0] DB_HI_LO     = 8'hA1;
  localparam logic [7:0] DB_HI_HI     = 8'hFE;
  localparam logic [7:0] GB2312_LEAD_HI = 8'hF7;
  localparam logic [7:0] GBK_LEAD_LO  = 8'h81;
  localparam logic [7:0] LOW_TRAIL_LO = 8'h40;
  localparam logic [7:0] BIG5_LOW_HI  = 8'h7E;
  localparam logic [7:0] BIG5_LEAD_HI = 8'hF9;

  typedef struct packed {
    logic       trail_ok;    // byte passes the trail rule
    logic       lead_bad;    // byte is no valid lead
    logic [1:0] lead_trails; // trail bytes owed if taken as lead
    logic       last;        // final byte of the stream
  } class_t;

endpackage

`default_nettype wire

/* src/multibyte_text_validator.sv */
// out_valid rises once an accepted last byte has passed a queue slot and then the state update
// throughput: one byte per cycle, held only by a full queue or an unread answer
// only a last byte waits on an unread answer; the two-entry queue then fills and drops in_ready
// rst (synchronous, active high) empties the queue, clears trail count and failure flag,
// drops out_valid and sets encoding_mode to utf-8
// ----------------------------------------------------------------------------
// multibyte_text_validator
// checks a byte stream against utf-8, gb2312, gbk or big5 and answers at the last byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multibyte_text_validator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration
  input  wire logic       cfg_write,
  input  wire logic [1:0] cfg_data,
  // byte items in
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_value,
  input  wire logic       last_byte,
  // answer items out
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            stream_valid
);

  // active encoding; write it only while the block is idle (the block does not enforce this)
  mtv_pkg::mode_t  encoding_mode;

  mtv_pkg::class_t front_item;
  mtv_pkg::class_t head_item;
  logic            head_valid;
  logic            q_not_full;
  logic            pop;
  logic            push;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= mtv_pkg::MODE_UTF8;
    end else if (cfg_write) begin
      encoding_mode <= mtv_pkg::mode_t'(cfg_data);
    end
  end

  // front: classify each byte as it arrives, with no dependence on stream state
  mtv_front u_front (
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .mode       (encoding_mode),
    .item       (front_item)
  );

  // the queue takes a byte whenever it has room
  assign in_ready = q_not_full;
  assign push     = in_valid && in_ready;

  mtv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head_item (head_item)
  );

  // back: trail count, sticky failure and the registered answer
  mtv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stream_valid (stream_valid)
  );

endmodule

`default_nettype wire

/* src/mtv_front.sv */
// ----------------------------------------------------------------------------
// mtv_front
// classifies one byte against the lead and trail rules of the active mode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtv_front (
  input  wire logic [7:0]        byte_value,
  input  wire logic              last_byte,
  input  wire mtv_pkg::mode_t    mode,
  output mtv_pkg::class_t        item
);

  logic       trail_ok;
  logic       lead_bad;
  logic [1:0] lead_trails;

  always_comb begin
    trail_ok    = 1'b0;
    lead_bad    = 1'b0;
    lead_trails = 2'd0;
    unique case (mode)
      mtv_pkg::MODE_UTF8: begin
        trail_ok = (byte_value >= mtv_pkg::U8_CONT_LO) && (byte_value <= mtv_pkg::U8_CONT_HI);
        if (byte_value <= mtv_pkg::ASCII_TOP) begin
          lead_trails = 2'd0;
        end else if (byte_value < mtv_pkg::U8_LEAD2_LO) begin
          lead_bad = 1'b1;
        end else if (byte_value < mtv_pkg::U8_LEAD3_LO) begin
          lead_trails = 2'd1;
        end else if (byte_value < mtv_pkg::U8_LEAD4_LO) begin
          lead_trails = 2'd2;
        end else if (byte_value < mtv_pkg::U8_LEAD_END) begin
          lead_trails = 2'd3;
        end else begin
          lead_bad = 1'b1;
        end
      end
      mtv_pkg::MODE_GB2312: begin
        trail_ok = (byte_value >= mtv_pkg::DB_HI_LO) && (byte_value <= mtv_pkg::DB_HI_HI);
        if (byte_value > mtv_pkg::ASCII_TOP) begin
          lead_bad    = !((byte_value >= mtv_pkg::DB_HI_LO) &&
                          (byte_value <= mtv_pkg::GB2312_LEAD_HI));
          lead_trails = 2'd1;
        end
      end
      mtv_pkg::MODE_GBK: begin
        trail_ok = (byte_value >= mtv_pkg::LOW_TRAIL_LO) && (byte_value <= mtv_pkg::DB_HI_HI);
        if (byte_value > mtv_pkg::ASCII_TOP) begin
          lead_bad    = !((byte_value >= mtv_pkg::GBK_LEAD_LO) &&
                          (byte_value <= mtv_pkg::DB_HI_HI));
          lead_trails = 2'd1;
        end
      end
      mtv_pkg::MODE_BIG5: begin
        trail_ok = ((byte_value >= mtv_pkg::LOW_TRAIL_LO) &&
                    (byte_value <= mtv_pkg::BIG5_LOW_HI)) ||
                   ((byte_value >= mtv_pkg::DB_HI_LO) && (byte_value <= mtv_pkg::DB_HI_HI));
        if (byte_value > mtv_pkg::ASCII_TOP) begin
          lead_bad    = !((byte_value >= mtv_pkg::DB_HI_LO) &&
                          (byte_value <= mtv_pkg::BIG5_LEAD_HI));
          lead_trails = 2'd1;
        end
      end
      default: begin
        lead_bad = 1'b1;
      end
    endcase
  end

  assign item.trail_ok    = trail_ok;
  assign item.lead_bad    = lead_bad;
  assign item.lead_trails = lead_trails;
  assign item.last        = last_byte;

endmodule

`default_nettype wire

/* src/mtv_queue.sv */
// ----------------------------------------------------------------------------
// mtv_queue
// small register queue of classified items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multibyte_text_validator_assert.svh"

module mtv_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mtv_pkg::class_t push_item,
  output logic                 not_full,
  input  wire logic            pop,
  output logic                 not_empty,
  output mtv_pkg::class_t      head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mtv_pkg::class_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign not_full  = (count != FULL_CNT);
  assign not_empty = (count != '0);
  assign head_item = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `MTV_ASSERT_NOW(a_no_pop_empty, pop, count != '0, "queue popped while empty")
  `MTV_ASSERT_NOW(a_no_push_full, push, count != FULL_CNT, "queue pushed while full")
  `MTV_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_CNT, "queue count past depth")

endmodule

`default_nettype wire

/* src/mtv_back.sv */
// ----------------------------------------------------------------------------
// mtv_back
// applies classified items to the stream state and holds the answer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multibyte_text_validator_assert.svh"

module mtv_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire mtv_pkg::class_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 stream_valid
);

  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       failed;
  logic       failed_next;
  logic       fin_pending_zero;
  logic       fin_failed;

  // a last item needs the answer register free, others always drain
  assign pop = head_valid && (!head_item.last || !out_valid || out_ready);

  always_comb begin
    fin_pending_zero = (pending == 2'd0);
    fin_failed       = failed;
    if (!failed) begin
      if (pending != 2'd0) begin
        if (head_item.trail_ok) begin
          fin_pending_zero = (pending == 2'd1);
        end else begin
          fin_failed = 1'b1;
        end
      end else if (head_item.lead_bad) begin
        fin_failed = 1'b1;
      end else begin
        fin_pending_zero = (head_item.lead_trails == 2'd0);
      end
    end
  end

  always_comb begin
    pending_next = pending;
    failed_next  = failed;
    if (pop) begin
      if (head_item.last) begin
        pending_next = 2'd0;
        failed_next  = 1'b0;
      end else if (!failed) begin
        if (pending != 2'd0) begin
          if (head_item.trail_ok) begin
            pending_next = pending - 2'd1;
          end else begin
            failed_next = 1'b1;
          end
        end else if (head_item.lead_bad) begin
          failed_next = 1'b1;
        end else begin
          pending_next = head_item.lead_trails;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 2'd0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pending <= pending_next;
      failed  <= failed_next;
      if (pop && head_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      stream_valid <= fin_pending_zero && !fin_failed;
    end
  end

  `MTV_ASSERT_NEXT(a_clear_after_last, pop && head_item.last,
                   pending == 2'd0 && !failed, "stream state not cleared after last item")
  `MTV_ASSERT_NEXT(a_failed_sticky, failed && !(pop && head_item.last), failed,
                   "failure flag dropped mid stream")
  `MTV_ASSERT_NOW(a_pending_frozen, failed, pending_next == pending || (pop && head_item.last),
                  "trail count moved after failure")

endmodule

`default_nettype wire
